FILE: hdl/buffer_handle_free_list_assert.svh
// Assertion macros for the buffer handle free list.
// Both forms sample on clk and stay quiet while rst_n is low.
`ifndef BUFFER_HANDLE_FREE_LIST_ASSERT_SVH
`define BUFFER_HANDLE_FREE_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge.
`define BHFL_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition implies another at the next clock edge.
`define BHFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BHFL_ASSERT_ALWAYS(label, expr)
`define BHFL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/bhfl_pkg.sv
`timescale 1ns / 1ps

package bhfl_pkg;

    // Ring geometry
    localparam int DEPTH    = 1024;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int HANDLE_W = 10;
    localparam int COUNT_W  = 10;
    localparam int SIZE_W   = 16;
    localparam int ADDR_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_BYTES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b1;

    localparam logic [SIZE_W-1:0] BUF_BYTES_RESET = 16'd2048;
    localparam logic [ADDR_W-1:0] BASE_ADDR_RESET = 32'd0;

    // Command codes
    localparam logic CMD_TAKE   = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RETURNED = 2'd2,
        ST_DROPPED  = 2'd3
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [HANDLE_W-1:0]  granted_handle;
        logic [ADDR_W-1:0]    granted_address;
        logic [COUNT_W-1:0]   free_count;
        logic                 is_empty;
        logic                 is_full;
    } result_t;

    // Advance a ring index with wrap at DEPTH.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(DEPTH - 1))
            r = '0;
        else
            r = i + IDX_W'(1);
        return r;
    endfunction

endpackage

FILE: hdl/buffer_handle_free_list.sv
`timescale 1ns / 1ps

// Buffer handle free list: a ring of free buffer handles that serves one take
// or return item per clock while in_stall is low, with no bubbles. After reset
// the ring holds handles 0 to DEPTH-2 with one slot kept spare, so DEPTH-1
// handles can be taken at once; the block is ready straight out of reset (no
// clearing pass: a write fill count stands in for the reset contents of the
// ring memory). A take pops the head handle and reports it with its byte
// address (base_address + handle * buffer size, 32-bit wrap); on an empty ring
// a no-wait take is refused, while a wait take is parked and answered by the
// next return, which hands its own handle straight to the waiting take. A
// return into a full ring is dropped with an overflow status. Each result
// carries the free count and the empty and full flags after the step. An
// item's result is registered in the output register, or in the skid while
// out_stall holds it; a parked wait take gives no result. The head of the
// ring is prefetched from the memory's registered read port each cycle, with
// a write bypass, which is what lets pops run back to back. A skid register
// behind the output keeps input stall a registered signal. Write the buffer
// size and base address registers only while the block is idle.

`include "buffer_handle_free_list_assert.svh"

module buffer_handle_free_list
(
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bhfl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bhfl_pkg::ADDR_W-1:0]       cfg_data,

    // Request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic                              wait_mode,
    input  logic [bhfl_pkg::HANDLE_W-1:0]     handle,

    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [bhfl_pkg::HANDLE_W-1:0]     granted_handle,
    output logic [bhfl_pkg::ADDR_W-1:0]       granted_address,
    output logic [bhfl_pkg::COUNT_W-1:0]      free_count,
    output logic                              is_empty,
    output logic                              is_full
);

    localparam int IDX_W = bhfl_pkg::IDX_W;

    // Ring state
    logic [IDX_W-1:0]             rd_reg, rd_next;
    logic [IDX_W-1:0]             wr_reg, wr_next;
    logic                         waiting_reg, waiting_next;
    logic [IDX_W:0]               fill_reg, fill_next;

    // Head prefetch
    logic [bhfl_pkg::HANDLE_W-1:0] ring_mem [bhfl_pkg::DEPTH];
    logic [bhfl_pkg::HANDLE_W-1:0] rdata_reg;
    logic                          byp_valid_reg, byp_valid_next;
    logic [bhfl_pkg::HANDLE_W-1:0] byp_data_reg;
    logic                          fresh_reg, fresh_next;
    logic [bhfl_pkg::HANDLE_W-1:0] head;

    // Configuration
    logic [bhfl_pkg::SIZE_W-1:0]   buf_bytes_reg;
    logic [bhfl_pkg::ADDR_W-1:0]   base_address_reg;

    // Output register and skid
    logic                          out_valid_reg;
    bhfl_pkg::result_t             out_data_reg;
    logic                          skid_valid_reg;
    bhfl_pkg::result_t             skid_data_reg;

    // Step logic
    logic                          accept;
    logic                          ring_empty;
    logic                          ring_full;
    logic [IDX_W-1:0]              wr_inc;
    logic                          pop;
    logic                          push;
    logic                          res_valid;
    logic                          granted;
    bhfl_pkg::status_t             res_status;
    logic [bhfl_pkg::HANDLE_W-1:0] grant_handle;
    logic [bhfl_pkg::ADDR_W-1:0]   grant_address;
    logic [IDX_W:0]                count_raw;
    bhfl_pkg::result_t             res;
    logic                          out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;

    assign ring_empty = (rd_reg == wr_reg);
    assign wr_inc     = bhfl_pkg::idx_inc(wr_reg);
    assign ring_full  = (wr_inc == rd_reg);

    // Head of the ring: freshest write first, then reset contents, then memory.
    always_comb
    begin
        if (byp_valid_reg)
            head = byp_data_reg;
        else if (fresh_reg)
            head = bhfl_pkg::HANDLE_W'(rd_reg);
        else
            head = rdata_reg;
    end

    // Decide what the accepted item does to the ring.
    always_comb
    begin
        pop          = 1'b0;
        push         = 1'b0;
        res_valid    = 1'b0;
        granted      = 1'b0;
        res_status   = bhfl_pkg::ST_EMPTY;
        grant_handle = head;
        waiting_next = waiting_reg;
        if (accept)
        begin
            case (cmd)
                bhfl_pkg::CMD_TAKE:
                begin
                    if (!ring_empty && !waiting_reg)
                    begin
                        pop        = 1'b1;
                        res_valid  = 1'b1;
                        granted    = 1'b1;
                        res_status = bhfl_pkg::ST_GRANTED;
                    end
                    else if (wait_mode)
                    begin
                        waiting_next = 1'b1;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res_status = bhfl_pkg::ST_EMPTY;
                    end
                end
                default:
                begin
                    res_valid = 1'b1;
                    if (ring_full)
                    begin
                        res_status = bhfl_pkg::ST_DROPPED;
                    end
                    else if (waiting_reg)
                    begin
                        // The ring is empty, so the pushed handle is the one popped.
                        push         = 1'b1;
                        pop          = 1'b1;
                        granted      = 1'b1;
                        grant_handle = handle;
                        res_status   = bhfl_pkg::ST_GRANTED;
                        waiting_next = 1'b0;
                    end
                    else
                    begin
                        push       = 1'b1;
                        res_status = bhfl_pkg::ST_RETURNED;
                    end
                end
            endcase
        end
    end

    assign rd_next = pop  ? bhfl_pkg::idx_inc(rd_reg) : rd_reg;
    assign wr_next = push ? wr_inc : wr_reg;

    // Count ring writes; entry j has been written once the count passes it
    // (the first write lands on the last entry, then writes run from zero up).
    assign fill_next = (push && fill_reg != (IDX_W+1)'(bhfl_pkg::DEPTH)) ?
                       fill_reg + (IDX_W+1)'(1) : fill_reg;

    assign fresh_next = !((fill_next != '0) &&
                          ((rd_next == IDX_W'(bhfl_pkg::DEPTH - 1)) ||
                           ({1'b0, fill_next} >= ({2'b00, rd_next} + (IDX_W+2)'(2)))));

    assign byp_valid_next = push && (wr_reg == rd_next);

    assign grant_address = base_address_reg +
                           bhfl_pkg::ADDR_W'(grant_handle) *
                           bhfl_pkg::ADDR_W'(buf_bytes_reg);

    // Free count after the step, saturated to the field width.
    always_comb
    begin
        if (wr_next >= rd_next)
            count_raw = {1'b0, wr_next} - {1'b0, rd_next};
        else
            count_raw = {1'b0, wr_next} + (IDX_W+1)'(bhfl_pkg::DEPTH) - {1'b0, rd_next};
    end

    always_comb
    begin
        res.status          = res_status;
        res.granted_handle  = granted ? grant_handle : '0;
        res.granted_address = granted ? grant_address : '0;
        if (count_raw > (IDX_W+1)'(bhfl_pkg::COUNT_MAX))
            res.free_count = bhfl_pkg::COUNT_MAX;
        else
            res.free_count = bhfl_pkg::COUNT_W'(count_raw);
        res.is_empty        = (rd_next == wr_next);
        res.is_full         = (bhfl_pkg::idx_inc(wr_next) == rd_next);
    end

    // Ring memory: one write port, registered read of the next head.
    always_ff @(posedge clk)
    begin
        if (push)
            ring_mem[wr_reg] <= handle;
        rdata_reg    <= ring_mem[rd_next];
        byp_data_reg <= handle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg        <= '0;
            wr_reg        <= IDX_W'(bhfl_pkg::DEPTH - 1);
            waiting_reg   <= 1'b0;
            fill_reg      <= '0;
            byp_valid_reg <= 1'b0;
            fresh_reg     <= 1'b1;
        end
        else
        begin
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            waiting_reg   <= waiting_next;
            fill_reg      <= fill_next;
            byp_valid_reg <= byp_valid_next;
            fresh_reg     <= fresh_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_bytes_reg    <= bhfl_pkg::BUF_BYTES_RESET;
            base_address_reg <= bhfl_pkg::BASE_ADDR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bhfl_pkg::CFG_BUF_BYTES:    buf_bytes_reg    <= cfg_data[bhfl_pkg::SIZE_W-1:0];
                bhfl_pkg::CFG_BASE_ADDRESS: base_address_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Output register with skid: drain skid first, hold while stalled.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (res_valid)
                out_data_reg <= res;
        end
        else if (res_valid)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_data_reg.status;
    assign granted_handle  = out_data_reg.granted_handle;
    assign granted_address = out_data_reg.granted_address;
    assign free_count      = out_data_reg.free_count;
    assign is_empty        = out_data_reg.is_empty;
    assign is_full         = out_data_reg.is_full;

    // A parked take only exists while the ring is empty.
    `BHFL_ASSERT_ALWAYS(a_wait_only_when_empty, !waiting_reg || (rd_reg == wr_reg))
    // The skid only fills behind a held output.
    `BHFL_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    // The write fill count never runs past the ring depth.
    `BHFL_ASSERT_ALWAYS(a_fill_bounded, fill_reg <= (IDX_W+1)'(bhfl_pkg::DEPTH))
    // Every pop advances the read index by one.
    `BHFL_ASSERT_NEXT(a_pop_advances, pop, rd_reg == bhfl_pkg::idx_inc($past(rd_reg)))

endmodule
